// ===== hw/rtl/snf_pkg.sv =====
// shared types and constants of the sei nal framer
`timescale 1ns / 1ps

package snf_pkg;

    // input word fields
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 12;

    // default payload length limit
    localparam int MAX_PAYLOAD_DEFAULT = 4095;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // configuration register map
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam logic REG_CODEC_SELECT = 1'b0;

    // codec codes
    localparam logic CODEC_H264 = 1'b0;
    localparam logic CODEC_HEVC = 1'b1;

    // fixed stream bytes
    localparam logic [BYTE_W-1:0] SC_ZERO      = 8'h00;
    localparam logic [BYTE_W-1:0] SC_ONE       = 8'h01;
    localparam logic [BYTE_W-1:0] HDR_H264     = 8'h06;
    localparam logic [BYTE_W-1:0] HDR_HEVC_0   = 8'h4E;
    localparam logic [BYTE_W-1:0] HDR_HEVC_1   = 8'h01;
    localparam logic [BYTE_W-1:0] SEI_TYPE     = 8'd100;
    localparam logic [BYTE_W-1:0] SIZE_FF      = 8'hFF;
    localparam logic [LEN_W-1:0]  SIZE_STEP    = 12'd255;
    localparam logic [BYTE_W-1:0] TRAILER_BYTE = 8'h80;
    localparam logic [BYTE_W-1:0] ESC_BYTE     = 8'h03;
    localparam logic [BYTE_W-1:0] ESC_LIMIT    = 8'h03;

    // one classified word handed from front to back
    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic              start;
        logic [LEN_W-1:0]  length;
        logic              last;
    } cmd_t;

endpackage

// ===== hw/rtl/snf_front.sv =====
// front part: accepts input words, tracks the open unit, builds commands
`timescale 1ns / 1ps

module snf_front #(
    parameter int MAX_PAYLOAD = snf_pkg::MAX_PAYLOAD_DEFAULT
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [snf_pkg::BYTE_W-1:0] s_payload_byte,
    input  logic                      s_start_req,
    input  logic [snf_pkg::LEN_W-1:0] s_payload_length,
    input  logic                      q_full,
    output logic                      q_push,
    output snf_pkg::cmd_t             q_cmd
);

    logic                      in_unit_reg, in_unit_next;
    logic [snf_pkg::LEN_W-1:0] bytes_left_reg, bytes_left_next;
    logic [snf_pkg::LEN_W-1:0] len_fix;
    logic [snf_pkg::LEN_W-1:0] len_sat;
    logic                      accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // length clean-up: zero taken as one, clamp to limit
    always_comb begin
        len_fix = (s_payload_length == '0) ? snf_pkg::LEN_W'(1) : s_payload_length;
        if (32'(len_fix) > MAX_PAYLOAD) begin
            len_sat = snf_pkg::LEN_W'(MAX_PAYLOAD);
        end else begin
            len_sat = len_fix;
        end
    end

    // classify the word and update unit tracking
    always_comb begin
        in_unit_next            = in_unit_reg;
        bytes_left_next         = bytes_left_reg;
        q_push                  = 1'b0;
        q_cmd.payload_byte      = s_payload_byte;
        q_cmd.start             = s_start_req;
        q_cmd.length            = len_sat;
        q_cmd.last              = 1'b0;
        if (s_start_req) begin
            q_cmd.last = (len_sat == snf_pkg::LEN_W'(1));
        end else begin
            q_cmd.last = (bytes_left_reg == snf_pkg::LEN_W'(1));
        end
        if (accept) begin
            if (s_start_req) begin
                q_push          = 1'b1;
                bytes_left_next = len_sat - snf_pkg::LEN_W'(1);
                in_unit_next    = !q_cmd.last;
            end else if (in_unit_reg) begin
                q_push          = 1'b1;
                bytes_left_next = bytes_left_reg - snf_pkg::LEN_W'(1);
                in_unit_next    = !q_cmd.last;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_unit_reg    <= 1'b0;
            bytes_left_reg <= '0;
        end else begin
            in_unit_reg    <= in_unit_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

    // no unit open means no bytes outstanding
    a_idle_count: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_unit_reg |-> bytes_left_reg == '0)
        else $error("bytes outstanding with no open unit");

endmodule

// ===== hw/rtl/snf_queue.sv =====
// short command queue between front and back
`timescale 1ns / 1ps

module snf_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  snf_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output snf_pkg::cmd_t head_cmd
);

    localparam int CNT_W = $clog2(snf_pkg::QUEUE_DEPTH + 1);

    snf_pkg::cmd_t                  slot_reg [snf_pkg::QUEUE_DEPTH];
    logic [snf_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [snf_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]               count_reg, count_next;

    assign full       = (count_reg == CNT_W'(snf_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == snf_pkg::QPTR_W'(snf_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + snf_pkg::QPTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == snf_pkg::QPTR_W'(snf_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + snf_pkg::QPTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // no overflow, no underflow
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (push |-> !full) and (pop |-> head_valid))
        else $error("queue overrun or underrun");

endmodule

// ===== hw/rtl/snf_back.sv =====
// back part: expands commands into stream bytes with emulation prevention
`timescale 1ns / 1ps

module snf_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       codec_select,
    input  logic                       head_valid,
    input  snf_pkg::cmd_t              head_cmd,
    output logic                       pop,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [snf_pkg::BYTE_W-1:0] m_out_byte,
    output logic                       m_run_last,
    output logic                       m_nal_end
);

    // sequencer phases
    localparam logic [3:0] PH_FIRST   = 4'd0;
    localparam logic [3:0] PH_SC0     = 4'd1;
    localparam logic [3:0] PH_SC1     = 4'd2;
    localparam logic [3:0] PH_SC2     = 4'd3;
    localparam logic [3:0] PH_SC3     = 4'd4;
    localparam logic [3:0] PH_HDR0    = 4'd5;
    localparam logic [3:0] PH_HDR1    = 4'd6;
    localparam logic [3:0] PH_TYPE    = 4'd7;
    localparam logic [3:0] PH_SIZE    = 4'd8;
    localparam logic [3:0] PH_DATA    = 4'd9;
    localparam logic [3:0] PH_TRAILER = 4'd10;

    logic [3:0]                phase_reg, phase_next;
    logic [snf_pkg::LEN_W-1:0] rem_reg, rem_next;
    logic [1:0]                zr_reg, zr_next;
    logic                      m_valid_reg, m_valid_next;
    logic [snf_pkg::BYTE_W-1:0] m_out_byte_reg, m_out_byte_next;
    logic                      m_run_last_reg, m_run_last_next;
    logic                      m_nal_end_reg, m_nal_end_next;

    logic [3:0]                eff;
    logic [3:0]                nxt;
    logic [snf_pkg::BYTE_W-1:0] byte_val;
    logic                      rbsp;
    logic                      done;
    logic                      is_end;
    logic                      esc;
    logic                      out_free;
    logic                      fire;

    assign out_free = !m_valid_reg || m_ready;
    assign fire     = head_valid && out_free;

    // byte for the current phase
    always_comb begin
        eff = phase_reg;
        if (phase_reg == PH_FIRST) begin
            eff = head_cmd.start ? PH_SC0 : PH_DATA;
        end
        byte_val = snf_pkg::SC_ZERO;
        rbsp     = 1'b0;
        nxt      = PH_FIRST;
        done     = 1'b0;
        is_end   = 1'b0;
        case (eff)
            PH_SC0: begin
                nxt = PH_SC1;
            end
            PH_SC1: begin
                nxt = PH_SC2;
            end
            PH_SC2: begin
                nxt = PH_SC3;
            end
            PH_SC3: begin
                byte_val = snf_pkg::SC_ONE;
                nxt      = PH_HDR0;
            end
            PH_HDR0: begin
                if (codec_select == snf_pkg::CODEC_HEVC) begin
                    byte_val = snf_pkg::HDR_HEVC_0;
                    nxt      = PH_HDR1;
                end else begin
                    byte_val = snf_pkg::HDR_H264;
                    nxt      = PH_TYPE;
                end
            end
            PH_HDR1: begin
                byte_val = snf_pkg::HDR_HEVC_1;
                nxt      = PH_TYPE;
            end
            PH_TYPE: begin
                byte_val = snf_pkg::SEI_TYPE;
                rbsp     = 1'b1;
                nxt      = PH_SIZE;
            end
            PH_SIZE: begin
                rbsp = 1'b1;
                if (rem_reg >= snf_pkg::SIZE_STEP) begin
                    byte_val = snf_pkg::SIZE_FF;
                    nxt      = PH_SIZE;
                end else begin
                    byte_val = rem_reg[snf_pkg::BYTE_W-1:0];
                    nxt      = PH_DATA;
                end
            end
            PH_DATA: begin
                byte_val = head_cmd.payload_byte;
                rbsp     = 1'b1;
                if (head_cmd.last) begin
                    nxt = PH_TRAILER;
                end else begin
                    done = 1'b1;
                end
            end
            PH_TRAILER: begin
                byte_val = snf_pkg::TRAILER_BYTE;
                rbsp     = 1'b1;
                done     = 1'b1;
                is_end   = 1'b1;
            end
            default: begin
                done = 1'b1;
            end
        endcase
        esc = rbsp && (zr_reg == 2'd2) && (byte_val <= snf_pkg::ESC_LIMIT);
    end

    // advance sequencer and load the output register
    always_comb begin
        phase_next      = phase_reg;
        rem_next        = rem_reg;
        zr_next         = zr_reg;
        pop             = 1'b0;
        m_out_byte_next = m_out_byte_reg;
        m_run_last_next = m_run_last_reg;
        m_nal_end_next  = m_nal_end_reg;
        m_valid_next    = m_ready ? 1'b0 : m_valid_reg;
        if (fire) begin
            m_valid_next = 1'b1;
            if (esc) begin
                // escape byte goes out first, same phase repeats
                m_out_byte_next = snf_pkg::ESC_BYTE;
                m_run_last_next = 1'b0;
                m_nal_end_next  = 1'b0;
                zr_next         = 2'd0;
                phase_next      = eff;
            end else begin
                m_out_byte_next = byte_val;
                m_run_last_next = done;
                m_nal_end_next  = is_end;
                if (rbsp) begin
                    if (byte_val == '0) begin
                        zr_next = (zr_reg == 2'd2) ? zr_reg : zr_reg + 2'd1;
                    end else begin
                        zr_next = 2'd0;
                    end
                end
                if (eff == PH_SC0) begin
                    zr_next  = 2'd0;
                    rem_next = head_cmd.length;
                end
                if ((eff == PH_SIZE) && (rem_reg >= snf_pkg::SIZE_STEP)) begin
                    rem_next = rem_reg - snf_pkg::SIZE_STEP;
                end
                phase_next = done ? PH_FIRST : nxt;
                pop        = done;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_FIRST;
            zr_reg      <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            zr_reg      <= zr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        rem_reg        <= rem_next;
        m_out_byte_reg <= m_out_byte_next;
        m_run_last_reg <= m_run_last_next;
        m_nal_end_reg  <= m_nal_end_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_out_byte_reg;
    assign m_run_last = m_run_last_reg;
    assign m_nal_end  = m_nal_end_reg;

    // trailer closes the item and carries 0x80
    a_trailer_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_nal_end) |-> (m_run_last && m_out_byte == snf_pkg::TRAILER_BYTE))
        else $error("trailer byte malformed");

    // the queue head is released only on the last byte of a command
    a_pop_last: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> (m_valid && m_run_last))
        else $error("command released without a closing byte");

endmodule

// ===== hw/rtl/sei_nal_framer_with_emulation_prevention.sv =====
// top level of the sei nal framer with emulation prevention
//
//  channel | ports                                   | moves
//  --------+-----------------------------------------+----------------------------
//  input   | s_valid s_ready s_payload_byte ...      | one payload byte per word
//  output  | m_valid m_ready m_out_byte ...         | one stream byte per word
//  config  | psel penable pwrite paddr pwdata ...    | codec_select at address 0
//
// one output byte leaves the output register per cycle while m_ready is high and a
// command waits in the queue; a mid-payload word yields its byte, preceded by an escape
// byte when one is inserted, plus the trailer on the closing word; a start word yields
// up to 25 bytes, set by the byte sequencer in the back part.
// reset is synchronous on aresetn and clears control state only; no clearing pass.
// a four-word command queue lets input words keep arriving while output stalls.
`timescale 1ns / 1ps

module sei_nal_framer_with_emulation_prevention #(
    parameter int MAX_PAYLOAD = snf_pkg::MAX_PAYLOAD_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [snf_pkg::PADDR_W-1:0] paddr,
    input  logic [snf_pkg::PDATA_W-1:0] pwdata,
    output logic [snf_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    // input words
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [snf_pkg::BYTE_W-1:0]  s_payload_byte,
    input  logic                        s_start_req,
    input  logic [snf_pkg::LEN_W-1:0]   s_payload_length,
    // output words
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [snf_pkg::BYTE_W-1:0]  m_out_byte,
    output logic                        m_run_last,
    output logic                        m_nal_end
);

    logic          codec_select_reg, codec_select_next;
    logic          q_full;
    logic          q_push;
    snf_pkg::cmd_t q_cmd;
    logic          q_pop;
    logic          head_valid;
    snf_pkg::cmd_t head_cmd;

    // register write and read back
    assign pready = 1'b1;

    always_comb begin
        codec_select_next = codec_select_reg;
        if (psel && penable && pwrite && pready &&
            (paddr[snf_pkg::PADDR_W-1] == snf_pkg::REG_CODEC_SELECT)) begin
            codec_select_next = pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[snf_pkg::PADDR_W-1] == snf_pkg::REG_CODEC_SELECT) begin
            prdata = {{(snf_pkg::PDATA_W-1){1'b0}}, codec_select_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            codec_select_reg <= snf_pkg::CODEC_H264;
        end else begin
            codec_select_reg <= codec_select_next;
        end
    end

    // front part
    snf_front #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_payload_byte  (s_payload_byte),
        .s_start_req     (s_start_req),
        .s_payload_length(s_payload_length),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_cmd           (q_cmd)
    );

    // command queue
    snf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (q_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .head_valid(head_valid),
        .head_cmd  (head_cmd)
    );

    // back part
    snf_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .codec_select(codec_select_reg),
        .head_valid  (head_valid),
        .head_cmd    (head_cmd),
        .pop         (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_run_last  (m_run_last),
        .m_nal_end   (m_nal_end)
    );

endmodule

// ===== test/tb_sei_nal_framer_with_emulation_prevention.sv =====
// testbench for the sei nal framer: directed and random payload streams against a predictor
`timescale 1ns / 1ps

module tb_sei_nal_framer_with_emulation_prevention;

    localparam int DRAIN_CYCLES = 64;
    localparam logic [snf_pkg::PADDR_W-1:0] CODEC_ADDR =
        snf_pkg::PADDR_W'(4 * int'(snf_pkg::REG_CODEC_SELECT));

    // receiver stall modes, stepped through by the stall counter
    typedef enum logic [1:0] {RX_STEADY, RX_LIGHT, RX_HALF, RX_LONG} rx_mode_t;

    // one expected stream word
    typedef struct packed {
        logic [snf_pkg::BYTE_W-1:0] data;
        logic                       run_last;
        logic                       nal_end;
    } nal_byte_t;

    logic                         aclk             = 1'b0;
    logic                         aresetn          = 1'b0;
    logic                         psel             = 1'b0;
    logic                         penable          = 1'b0;
    logic                         pwrite           = 1'b0;
    logic [snf_pkg::PADDR_W-1:0]  paddr            = '0;
    logic [snf_pkg::PDATA_W-1:0]  pwdata           = '0;
    logic [snf_pkg::PDATA_W-1:0]  prdata;
    logic                         pready;
    logic                         s_valid          = 1'b0;
    logic                         s_ready;
    logic [snf_pkg::BYTE_W-1:0]   s_payload_byte   = '0;
    logic                         s_start_req      = 1'b0;
    logic [snf_pkg::LEN_W-1:0]    s_payload_length = '0;
    logic                         m_valid;
    logic                         m_ready          = 1'b0;
    logic [snf_pkg::BYTE_W-1:0]   m_out_byte;
    logic                         m_run_last;
    logic                         m_nal_end;

    // predictor state
    logic                         codec_sel = snf_pkg::CODEC_H264;
    logic [1:0]                   zero_cnt  = 2'd0;
    logic [snf_pkg::LEN_W-1:0]    remaining = '0;
    logic                         unit_open = 1'b0;
    nal_byte_t                    nal_bytes_due[$];

    int                  mismatches   = 0;
    int                  units_opened = 0;
    int                  units_cut    = 0;
    int                  escapes_due  = 0;
    int                  bytes_seen   = 0;
    int                  burst_left   = 0;
    logic [9:0]          stall_cnt    = '0;
    nal_byte_t           got;
    nal_byte_t           want;

    sei_nal_framer_with_emulation_prevention dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_payload_byte   (s_payload_byte),
        .s_start_req      (s_start_req),
        .s_payload_length (s_payload_length),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_run_last       (m_run_last),
        .m_nal_end        (m_nal_end)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // unescaped byte straight into the expected stream
    function automatic void emit_raw(input logic [snf_pkg::BYTE_W-1:0] b,
                                     input logic closes);
        nal_byte_t e;
        e.data     = b;
        e.run_last = 1'b0;
        e.nal_end  = closes;
        nal_bytes_due.insert(nal_bytes_due.size(), e);
    endfunction

    // rbsp byte, with an escape after two zeros when the byte is small
    function automatic void emit_rbsp(input logic [snf_pkg::BYTE_W-1:0] b,
                                      input logic closes);
        if (zero_cnt == 2'd2 && b <= snf_pkg::ESC_LIMIT) begin
            emit_raw(snf_pkg::ESC_BYTE, 1'b0);
            zero_cnt = 2'd0;
            escapes_due++;
        end
        emit_raw(b, closes);
        if (b == 8'h00) begin
            if (zero_cnt != 2'd2)
                zero_cnt = zero_cnt + 2'd1;
        end else begin
            zero_cnt = 2'd0;
        end
    endfunction

    // expected stream words for one accepted input word
    function automatic void frame_word(input logic [snf_pkg::BYTE_W-1:0] b, input logic st,
                                       input logic [snf_pkg::LEN_W-1:0] len_in);
        int        len;
        int        rem;
        nal_byte_t tail;
        if (st) begin
            // zero length counts as one, anything above the limit saturates
            len = (len_in == '0) ? 1 : int'(len_in);
            if (len > snf_pkg::MAX_PAYLOAD_DEFAULT)
                len = snf_pkg::MAX_PAYLOAD_DEFAULT;
            if (unit_open)
                units_cut++;
            units_opened++;
            emit_raw(snf_pkg::SC_ZERO, 1'b0);
            emit_raw(snf_pkg::SC_ZERO, 1'b0);
            emit_raw(snf_pkg::SC_ZERO, 1'b0);
            emit_raw(snf_pkg::SC_ONE, 1'b0);
            if (codec_sel == snf_pkg::CODEC_HEVC) begin
                emit_raw(snf_pkg::HDR_HEVC_0, 1'b0);
                emit_raw(snf_pkg::HDR_HEVC_1, 1'b0);
            end else begin
                emit_raw(snf_pkg::HDR_H264, 1'b0);
            end
            zero_cnt = 2'd0;
            emit_rbsp(snf_pkg::SEI_TYPE, 1'b0);
            rem = len;
            while (rem >= int'(snf_pkg::SIZE_STEP)) begin
                emit_rbsp(snf_pkg::SIZE_FF, 1'b0);
                rem -= int'(snf_pkg::SIZE_STEP);
            end
            emit_rbsp(snf_pkg::BYTE_W'(rem), 1'b0);
            unit_open = 1'b1;
            remaining = snf_pkg::LEN_W'(len);
        end else if (!unit_open) begin
            // stray byte outside a unit is dropped
            return;
        end
        emit_rbsp(b, 1'b0);
        remaining = remaining - snf_pkg::LEN_W'(1);
        if (remaining == '0) begin
            emit_rbsp(snf_pkg::TRAILER_BYTE, 1'b1);
            unit_open = 1'b0;
            zero_cnt  = 2'd0;
        end
        tail = nal_bytes_due.pop_back();
        tail.run_last = 1'b1;
        nal_bytes_due.insert(nal_bytes_due.size(), tail);
    endfunction

    // ------------------------------------------------------------------
    // receiver stalls and output check
    // ------------------------------------------------------------------

    // stall pattern cycles through steady, light, half and long stalls
    always @(posedge aclk) begin
        stall_cnt <= stall_cnt + 10'd1;
        case (rx_mode_t'(stall_cnt[9:8]))
            RX_STEADY: m_ready <= 1'b1;
            RX_LIGHT:  m_ready <= ($urandom_range(0, 3) != 0);
            RX_HALF:   m_ready <= ($urandom_range(0, 1) != 0);
            RX_LONG:   m_ready <= (stall_cnt[3:0] >= 4'd13);
            default:   m_ready <= 1'b1;
        endcase
    end

    // compare each accepted stream word with the oldest expected one
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got.data     = m_out_byte;
            got.run_last = m_run_last;
            got.nal_end  = m_nal_end;
            bytes_seen++;
            if (nal_bytes_due.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected word: expected none, actual byte %02h",
                         $time, got.data);
            end else begin
                want = nal_bytes_due.pop_front();
                if (got.data !== want.data) begin
                    mismatches++;
                    $display("%0t: out_byte: expected %02h, actual %02h",
                             $time, want.data, got.data);
                end
                if (got.run_last !== want.run_last) begin
                    mismatches++;
                    $display("%0t: run_last: expected %0b, actual %0b",
                             $time, want.run_last, got.run_last);
                end
                if (got.nal_end !== want.nal_end) begin
                    mismatches++;
                    $display("%0t: nal_end: expected %0b, actual %0b",
                             $time, want.nal_end, got.nal_end);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // shared tasks
    // ------------------------------------------------------------------

    // send one input word, with random gaps between bursts
    task automatic send_word(input logic [snf_pkg::BYTE_W-1:0] b, input logic st,
                             input logic [snf_pkg::LEN_W-1:0] len);
        int gap;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(1, 40);
        end
        s_valid          <= 1'b1;
        s_payload_byte   <= b;
        s_start_req      <= st;
        s_payload_length <= len;
        do @(posedge aclk); while (!s_ready);
        frame_word(b, st, len);
        burst_left--;
    endtask

    // hold the sender until every expected word has come, then settle
    task automatic wait_idle(input int extra);
        s_valid <= 1'b0;
        do @(posedge aclk); while (nal_bytes_due.size() != 0);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic apb_read(input logic [snf_pkg::PADDR_W-1:0] addr,
                            output logic [snf_pkg::PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // write codec select, read it back and update the predictor
    task automatic set_codec(input logic value);
        logic [snf_pkg::PDATA_W-1:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CODEC_ADDR;
        pwdata  <= snf_pkg::PDATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        codec_sel = value;
        @(posedge aclk);
        apb_read(CODEC_ADDR, rd);
        if (rd !== snf_pkg::PDATA_W'(value)) begin
            mismatches++;
            $display("%0t: codec_select read: expected %08h, actual %08h",
                     $time, snf_pkg::PDATA_W'(value), rd);
        end
    endtask

    // payload byte biased towards zeros and escape-sized values
    function automatic logic [snf_pkg::BYTE_W-1:0] pick_payload_byte();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 8'h00;
            4, 5:       return snf_pkg::BYTE_W'($urandom_range(1, 3));
            default:    return snf_pkg::BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset value, then an explicit write of the default
    task automatic test_codec_register();
        logic [snf_pkg::PDATA_W-1:0] rd;
        apb_read(CODEC_ADDR, rd);
        if (rd !== snf_pkg::PDATA_W'(snf_pkg::CODEC_H264)) begin
            mismatches++;
            $display("%0t: codec_select after reset: expected %08h, actual %08h",
                     $time, snf_pkg::PDATA_W'(snf_pkg::CODEC_H264), rd);
        end
        @(posedge aclk);
        set_codec(snf_pkg::CODEC_H264);
    endtask

    // field extremes, escapes, stray bytes and cut-short units
    task automatic test_directed_stream();
        // shortest units, zero length and a stray byte
        send_word(8'h00, 1'b1, 12'd1);
        send_word(8'hFF, 1'b1, 12'd0);
        send_word(8'h55, 1'b0, 12'hFFF);
        // escape before a small byte after two zeros
        send_word(8'h00, 1'b1, 12'd3);
        send_word(8'h00, 1'b0, 12'd0);
        send_word(8'h03, 1'b0, 12'd0);
        // two zeros then the trailer, no escape
        send_word(8'h00, 1'b1, 12'd2);
        send_word(8'h00, 1'b0, 12'd0);
        // size remainder of zero feeds the zero run
        send_word(8'h00, 1'b1, 12'd255);
        send_word(8'h02, 1'b0, 12'd0);
        // new start abandons the open unit
        send_word(8'h00, 1'b1, 12'd510);
        send_word(8'h03, 1'b0, 12'd0);
        wait_idle(DRAIN_CYCLES);
        set_codec(snf_pkg::CODEC_HEVC);
        // largest length, zero runs needing escapes
        send_word(8'h00, 1'b1, 12'd4095);
        send_word(8'h00, 1'b0, 12'd0);
        send_word(8'h00, 1'b0, 12'd0);
        send_word(8'h00, 1'b1, 12'd4080);
        send_word(8'h01, 1'b0, 12'd0);
        send_word(8'h80, 1'b1, 12'd1);
        send_word(8'hAA, 1'b0, 12'd0);
        wait_idle(DRAIN_CYCLES);
    endtask

    // mostly complete units with random content, some cut short, some stray bytes
    task automatic test_random_units(input int target);
        int sent;
        int len;
        int eff;
        int n;
        int k;
        bit paused;
        int long_lens[7] = '{254, 255, 256, 509, 510, 765, 4095};
        sent   = 0;
        paused = 1'b0;
        while (sent < target) begin
            case ($urandom_range(0, 19))
                0:       len = 0;
                1:       len = long_lens[$urandom_range(0, 6)];
                2, 3:    len = $urandom_range(17, 64);
                default: len = $urandom_range(1, 16);
            endcase
            eff = (len == 0) ? 1 : len;
            if (eff > 48)
                n = $urandom_range(1, 24);
            else if (eff > 1 && $urandom_range(0, 9) == 0)
                n = $urandom_range(1, eff - 1);
            else
                n = eff;
            send_word(pick_payload_byte(), 1'b1, snf_pkg::LEN_W'(len));
            for (k = 1; k < n; k++)
                send_word(pick_payload_byte(), 1'b0,
                          snf_pkg::LEN_W'($urandom_range(0, 4095)));
            sent += n;
            // stray bytes only land outside a unit
            if (n == eff && $urandom_range(0, 7) == 0) begin
                for (k = $urandom_range(1, 3); k > 0; k--)
                    send_word(snf_pkg::BYTE_W'($urandom_range(0, 255)), 1'b0,
                              snf_pkg::LEN_W'($urandom_range(0, 4095)));
            end
            if (!paused && sent >= target / 2) begin
                wait_idle(0);
                paused = 1'b1;
            end
        end
        wait_idle(DRAIN_CYCLES);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_codec_register();
        test_directed_stream();
        test_random_units(160);
        set_codec(snf_pkg::CODEC_H264);
        test_random_units(160);
        set_codec(snf_pkg::CODEC_HEVC);
        test_random_units(160);

        $display("covered %0d units (%0d cut short by a new start), both codecs",
                 units_opened, units_cut);
        $display("%0d stream words checked, %0d of them escape bytes",
                 bytes_seen, escapes_due);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("%0t: timed out with %0d stream words outstanding",
                 $time, nal_bytes_due.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
